>>> rtl/diff_drive_odometry_gyro_fused_macros.svh
// Assertion macros for the odometry block checker.
// No dependencies; included by the checker file.
`ifndef DIFF_DRIVE_ODOMETRY_GYRO_FUSED_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_GYRO_FUSED_MACROS_SVH

// Clocked property, disabled during reset.
`define DDO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold.
`define DDO_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/ddo_pkg.sv
// Shared types, constants and tables for the odometry block.
// No dependencies; used by every other RTL file except the macro header.
package ddo_pkg;

  localparam int CNT_W     = 32;
  localparam int YAW_W     = 20;
  localparam int US_W      = 20;
  localparam int POS_W     = 32;
  localparam int HDG_W     = 31;
  localparam int SPD_W     = 32;
  localparam int MPT_W     = 24;
  localparam int IWB_W     = 24;
  localparam int GW_W      = 17;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int TICK_W    = 16;

  localparam int MDU_A_W     = 66;
  localparam int MDU_B_W     = 24;
  localparam int MDU_N_W     = 64;
  localparam int MDU_D_W     = 32;
  localparam int MDU_R_W     = 68;
  localparam int MDU_MUL_CYC = 24;
  localparam int MDU_DIV_CYC = 64;
  localparam int MDU_CNT_W   = 7;

  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032875;
  localparam logic signed [31:0] TICK_LIM    = 32'sd32767;
  localparam logic [47:0]        ENC_LIM     = 48'h4000_0000_0000;
  localparam logic [23:0]        US_PER_S    = 24'd1000000;
  localparam logic [GW_W-1:0]    W_ONE       = 17'd65536;

  // ceil(2^59 / 15625) split into high and low 24-bit halves
  localparam logic [MDU_B_W-1:0] GYR_RCP_HI  = 24'd2199023;
  localparam logic [MDU_B_W-1:0] GYR_RCP_LO  = 24'd4287452;
  localparam int                 GYR_RCP_SH  = 29;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MPT = 2'd0,
    CFG_IWB = 2'd1,
    CFG_GW  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } mdu_op_t;

  typedef struct packed {
    logic                        start;
    mdu_op_t                     op;
    logic                        accum;
    logic                        neg;
    logic signed [MDU_A_W-1:0]   a;
    logic        [MDU_B_W-1:0]   b;
    logic        [MDU_N_W-1:0]   num;
    logic        [MDU_D_W-1:0]   den;
  } ddo_cmd_t;

  typedef struct packed {
    logic                        done;
    logic signed [MDU_R_W-1:0]   res;
  } ddo_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SUMM, ST_DIFM, ST_ENCM, ST_GYRM, ST_GYRL, ST_GYRD, ST_BLDG,
    ST_BLDE, ST_CWRP, ST_CRED, ST_CORD, ST_CFIN, ST_XMUL, ST_YMUL, ST_LINM,
    ST_LIND, ST_TRNM, ST_TRND, ST_OUT
  } ddo_state_t;

  function automatic logic [27:0] atan_q28(input logic [4:0] i);
    logic [27:0] v;
    case (i)
      5'd0:  v = 28'd210828714;
      5'd1:  v = 28'd124459457;
      5'd2:  v = 28'd65760959;
      5'd3:  v = 28'd33381290;
      5'd4:  v = 28'd16755422;
      5'd5:  v = 28'd8385879;
      5'd6:  v = 28'd4193963;
      5'd7:  v = 28'd2097109;
      5'd8:  v = 28'd1048571;
      5'd9:  v = 28'd524287;
      5'd10: v = 28'd262144;
      5'd11: v = 28'd131072;
      5'd12: v = 28'd65536;
      5'd13: v = 28'd32768;
      5'd14: v = 28'd16384;
      5'd15: v = 28'd8192;
      5'd16: v = 28'd4096;
      5'd17: v = 28'd2048;
      5'd18: v = 28'd1024;
      5'd19: v = 28'd512;
      5'd20: v = 28'd256;
      5'd21: v = 28'd128;
      5'd22: v = 28'd64;
      5'd23: v = 28'd32;
      5'd24: v = 28'd16;
      5'd25: v = 28'd8;
      5'd26: v = 28'd4;
      5'd27: v = 28'd2;
      5'd28: v = 28'd1;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ddo_in_if.sv
// Input channel: encoder counts, gyro rate and interval with valid/ready.
// Depends on ddo_pkg.
interface ddo_in_if import ddo_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [CNT_W-1:0] right_count;
  logic signed [CNT_W-1:0] left_count;
  logic signed [YAW_W-1:0] yaw_rate;
  logic        [US_W-1:0]  interval_us;

  modport source (output valid, right_count, left_count, yaw_rate, interval_us,
                  input ready);
  modport sink   (input valid, right_count, left_count, yaw_rate, interval_us,
                  output ready);
endinterface

>>> rtl/ddo_out_if.sv
// Result channel: pose, speeds and clip flag with valid/ready.
// Depends on ddo_pkg.
interface ddo_out_if import ddo_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [HDG_W-1:0] heading;
  logic signed [SPD_W-1:0] lin_speed;
  logic signed [SPD_W-1:0] turn_rate;
  logic                    delta_clipped;

  modport source (output valid, pos_x, pos_y, heading, lin_speed, turn_rate,
                  delta_clipped, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, lin_speed, turn_rate,
                  delta_clipped, output ready);
endinterface

>>> rtl/diff_drive_odometry_gyro_fused.sv
// Differential drive odometry with gyro fusion, top level.
// Depends on ddo_pkg, ddo_in_if, ddo_out_if and ddo_mdu.
//
// Use: in_ch carries cumulative right/left encoder counts, the gyro yaw
// rate and the interval; one transfer on in_ch yields exactly one transfer
// on out_ch with pose, heading, linear and turn speed and a clip flag.
// Configuration registers (wheel travel per tick, inverse wheel base, gyro
// weight) are written through cfg_we/cfg_idx/cfg_wdata, index 0..2; other
// indexes are dropped.
// The time from the input transfer to out_ch.valid is set by the shared
// multiply/divide unit: twelve multiplies and two divides, plus the
// CORDIC_STEPS rotations and the sequencing states. One item is in work at
// a time; in_ch.ready is high only while idle, so a new item is not taken
// before the result of the last one has been taken, and it waits longer
// while out_ch.ready is held low.
// Reset (rst_n low, synchronous) clears pose, heading and stored counts and
// loads the register defaults; the block is idle and ready after it.
// A stalled receiver holds out_ch.valid and the result stable; no new
// item is taken until the result transfers.
module diff_drive_odometry_gyro_fused import ddo_pkg::*; #(
  parameter int CORDIC_STEPS  = 16,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ddo_in_if.sink               in_ch,
  ddo_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IT_W      = $clog2(CORDIC_STEPS);
  localparam int POS_SHIFT = 46 - POS_FRAC_BITS;
  localparam int POS_DN    = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;
  localparam int POS_UP    = (POS_FRAC_BITS < 16) ? 16 - POS_FRAC_BITS : 0;

  function automatic logic signed [31:0] sat32(input logic signed [MDU_R_W-1:0] v);
    if (v > MDU_R_W'(32'sh7fff_ffff)) begin
      return 32'sh7fff_ffff;
    end else if (v < MDU_R_W'(-33'sh8000_0000)) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

  ddo_state_t state_r, state_nxt;
  logic       launched_r, launched_nxt;

  logic [MPT_W-1:0] mpt_r;
  logic [IWB_W-1:0] iwb_r;
  logic [GW_W-1:0]  gw_r;

  logic [CNT_W-1:0]         prev_r_r, prev_l_r;
  logic signed [TICK_W-1:0] dr_r, dl_r;
  logic signed [YAW_W-1:0]  yaw_r;
  logic [US_W-1:0]          us_r;
  logic                     clip_r;
  logic signed [40:0]       distc_r;
  logic signed [41:0]       ddiff_r;
  logic signed [47:0]       enc_r;
  logic [MDU_N_W-1:0]       num_r;
  logic                     num_neg_r;
  logic [37:0]              gyro_lo_r;
  logic signed [33:0]       gyro_r;
  logic signed [30:0]       delta_r;
  logic signed [33:0]       z_r, cx_r, cy_r;
  logic                     flip_r;
  logic [IT_W-1:0]          it_r;
  logic signed [25:0]       cos_r, sin_r;
  logic signed [31:0]       x_acc_r, y_acc_r;
  logic signed [30:0]       theta_r;
  logic signed [31:0]       lin_r, turn_r;

  ddo_cmd_t cmd;
  ddo_rsp_t rsp;

  logic                     accept;
  logic                     mdu_st;
  logic signed [31:0]       dr_raw, dl_raw;
  logic signed [16:0]       sum17, dif17;
  logic signed [41:0]       ddiff_mag;
  logic [GW_W-1:0]          wc;
  logic signed [25:0]       cos_mag, sin_mag;
  logic signed [MDU_R_W-1:0] res, res_mag, dfull, xsum, ysum, step;
  logic [MDU_R_W-1:0]       gyro_q;
  logic [53:0]              emag;
  logic [47:0]              emag_s;
  logic signed [32:0]       ang, ang_w;
  logic signed [33:0]       zr, zs, xs, ys;
  logic signed [33:0]       atan_z;
  logic signed [31:0]       tsum;
  logic signed [33:0]       xf, yf;

  ddo_mdu u_mdu (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .rsp  (rsp)
  );

  assign accept = (state_r == ST_IDLE) && in_ch.valid;
  assign dr_raw = in_ch.right_count - $signed(prev_r_r);
  assign dl_raw = $signed(prev_l_r) - in_ch.left_count;
  assign sum17  = 17'(dr_r) + 17'(dl_r);
  assign dif17  = 17'(dr_r) - 17'(dl_r);
  assign ddiff_mag = ddiff_r[41] ? -ddiff_r : ddiff_r;
  assign wc      = (gw_r > W_ONE) ? W_ONE : gw_r;
  assign cos_mag = cos_r[25] ? -cos_r : cos_r;
  assign sin_mag = sin_r[25] ? -sin_r : sin_r;
  assign res     = rsp.res;
  assign res_mag = res[MDU_R_W-1] ? -res : res;
  assign gyro_q  = ($unsigned(res) + MDU_R_W'(gyro_lo_r)) >> GYR_RCP_SH;
  assign emag    = res[65:12];
  assign emag_s  = (emag > 54'(ENC_LIM)) ? ENC_LIM : emag[47:0];
  assign dfull   = res >>> 16;
  assign step    = res >>> POS_SHIFT;
  assign xsum    = MDU_R_W'(x_acc_r) + step;
  assign ysum    = MDU_R_W'(y_acc_r) + step;
  assign ang     = 33'(theta_r) + 33'(delta_r >>> 1);
  assign ang_w   = (ang > 33'(PI_Q28)) ? ang - TWO_PI_Q28 :
                   (ang < -33'(PI_Q28)) ? ang + TWO_PI_Q28 : ang;
  assign zr      = (z_r > 34'(HALF_PI_Q28)) ? z_r - 34'(PI_Q28) :
                   (z_r < -34'(HALF_PI_Q28)) ? z_r + 34'(PI_Q28) : z_r;
  assign atan_z  = 34'({atan_q28(5'(it_r)), 2'b00});
  assign xs      = cx_r >>> it_r;
  assign ys      = cy_r >>> it_r;
  assign zs      = z_r[33] ? z_r + atan_z : z_r - atan_z;
  assign tsum    = 32'(theta_r) + 32'(delta_r);
  assign xf      = flip_r ? -cx_r : cx_r;
  assign yf      = flip_r ? -cy_r : cy_r;

  assign mdu_st = (state_r inside {ST_SUMM, ST_DIFM, ST_ENCM, ST_GYRM, ST_GYRL,
                                   ST_GYRD, ST_BLDG, ST_BLDE, ST_XMUL, ST_YMUL,
                                   ST_LINM, ST_LIND, ST_TRNM, ST_TRND});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_SUMM;
      ST_SUMM: if (rsp.done) state_nxt = ST_DIFM;
      ST_DIFM: if (rsp.done) state_nxt = ST_ENCM;
      ST_ENCM: if (rsp.done) state_nxt = ST_GYRM;
      ST_GYRM: if (rsp.done) state_nxt = ST_GYRL;
      ST_GYRL: if (rsp.done) state_nxt = ST_GYRD;
      ST_GYRD: if (rsp.done) state_nxt = ST_BLDG;
      ST_BLDG: if (rsp.done) state_nxt = ST_BLDE;
      ST_BLDE: if (rsp.done) state_nxt = ST_CWRP;
      ST_CWRP: state_nxt = ST_CRED;
      ST_CRED: state_nxt = ST_CORD;
      ST_CORD: if (it_r == IT_W'(CORDIC_STEPS - 1)) state_nxt = ST_CFIN;
      ST_CFIN: state_nxt = ST_XMUL;
      ST_XMUL: if (rsp.done) state_nxt = ST_YMUL;
      ST_YMUL: if (rsp.done) state_nxt = ST_LINM;
      ST_LINM: if (rsp.done) state_nxt = ST_LIND;
      ST_LIND: if (rsp.done) state_nxt = ST_TRNM;
      ST_TRNM: if (rsp.done) state_nxt = ST_TRND;
      ST_TRND: if (rsp.done) state_nxt = ST_OUT;
      ST_OUT:  if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // unit command and channel outputs
  always_comb begin
    cmd       = '0;
    cmd.op    = MDU_MUL;
    cmd.start = mdu_st && !launched_r;
    case (state_r)
      ST_SUMM: begin
        cmd.a = MDU_A_W'(sum17);
        cmd.b = mpt_r;
      end
      ST_DIFM: begin
        cmd.a = MDU_A_W'(dif17);
        cmd.b = mpt_r;
      end
      ST_ENCM: begin
        cmd.a = MDU_A_W'(ddiff_mag);
        cmd.b = iwb_r;
      end
      ST_GYRM: begin
        cmd.a = MDU_A_W'(yaw_r);
        cmd.b = MDU_B_W'(us_r);
      end
      ST_GYRL: begin
        cmd.a = MDU_A_W'(num_r);
        cmd.b = GYR_RCP_LO;
      end
      ST_GYRD: begin
        cmd.a = MDU_A_W'(num_r);
        cmd.b = GYR_RCP_HI;
      end
      ST_BLDG: begin
        cmd.a = MDU_A_W'(gyro_r);
        cmd.b = MDU_B_W'(wc);
      end
      ST_BLDE: begin
        cmd.a     = MDU_A_W'(enc_r);
        cmd.b     = MDU_B_W'(W_ONE - wc);
        cmd.accum = 1'b1;
      end
      ST_XMUL: begin
        cmd.a   = MDU_A_W'(distc_r);
        cmd.b   = MDU_B_W'(cos_mag);
        cmd.neg = cos_r[25];
      end
      ST_YMUL: begin
        cmd.a   = MDU_A_W'(distc_r);
        cmd.b   = MDU_B_W'(sin_mag);
        cmd.neg = sin_r[25];
      end
      ST_LINM: begin
        cmd.a = MDU_A_W'(distc_r);
        cmd.b = US_PER_S;
      end
      ST_TRNM: begin
        cmd.a = MDU_A_W'(delta_r);
        cmd.b = US_PER_S;
      end
      ST_LIND: begin
        cmd.op  = MDU_DIV;
        cmd.num = num_r;
        cmd.den = MDU_D_W'({us_r, 8'b0});
        cmd.neg = num_neg_r;
      end
      ST_TRND: begin
        cmd.op  = MDU_DIV;
        cmd.num = num_r;
        cmd.den = {us_r, 12'b0};
        cmd.neg = num_neg_r;
      end
      default: ;
    endcase

    in_ch.ready          = (state_r == ST_IDLE);
    out_ch.valid         = (state_r == ST_OUT);
    out_ch.pos_x         = sat32((MDU_R_W'(x_acc_r) <<< POS_UP) >>> POS_DN);
    out_ch.pos_y         = sat32((MDU_R_W'(y_acc_r) <<< POS_UP) >>> POS_DN);
    out_ch.heading       = theta_r;
    out_ch.lin_speed     = lin_r;
    out_ch.turn_rate     = turn_r;
    out_ch.delta_clipped = clip_r;
  end

  assign launched_nxt = (state_nxt != state_r) ? 1'b0 : (launched_r | cmd.start);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      launched_r <= 1'b0;
      mpt_r      <= 24'd9664;
      iwb_r      <= 24'd409600;
      gw_r       <= '0;
      prev_r_r   <= '0;
      prev_l_r   <= '0;
      x_acc_r    <= '0;
      y_acc_r    <= '0;
      theta_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_MPT: mpt_r <= cfg_wdata;
          CFG_IWB: iwb_r <= cfg_wdata;
          CFG_GW:  gw_r  <= cfg_wdata[GW_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        prev_r_r <= in_ch.right_count;
        prev_l_r <= in_ch.left_count;
      end
      if (state_r == ST_XMUL && rsp.done) x_acc_r <= sat32(xsum);
      if (state_r == ST_YMUL && rsp.done) y_acc_r <= sat32(ysum);
      if (state_r == ST_CFIN) begin
        theta_r <= (tsum > PI_Q28) ? 31'(tsum - 32'(TWO_PI_Q28)) :
                   (tsum < -PI_Q28) ? 31'(tsum + 32'(TWO_PI_Q28)) : 31'(tsum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dr_r   <= (dr_raw > TICK_LIM) ? 16'(TICK_LIM) :
                (dr_raw < -TICK_LIM) ? -16'(TICK_LIM) : 16'(dr_raw);
      dl_r   <= (dl_raw > TICK_LIM) ? 16'(TICK_LIM) :
                (dl_raw < -TICK_LIM) ? -16'(TICK_LIM) : 16'(dl_raw);
      clip_r <= (dr_raw > TICK_LIM) || (dr_raw < -TICK_LIM) ||
                (dl_raw > TICK_LIM) || (dl_raw < -TICK_LIM);
      yaw_r  <= in_ch.yaw_rate;
      us_r   <= in_ch.interval_us;
    end
    if (rsp.done) begin
      case (state_r)
        ST_SUMM: distc_r <= 41'(res >>> 1);
        ST_DIFM: ddiff_r <= 42'(res);
        ST_ENCM: enc_r   <= ddiff_r[41] ? -$signed(emag_s) : $signed(emag_s);
        ST_GYRL: gyro_lo_r <= 38'(res >>> 24);
        ST_GYRD: gyro_r  <= num_neg_r ? -34'(gyro_q) : 34'(gyro_q);
        ST_BLDE: begin
          if (dfull > MDU_R_W'(PI_Q28)) begin
            delta_r <= 31'(PI_Q28);
            clip_r  <= 1'b1;
          end else if (dfull < -MDU_R_W'(PI_Q28)) begin
            delta_r <= -31'(PI_Q28);
            clip_r  <= 1'b1;
          end else begin
            delta_r <= 31'(dfull);
          end
        end
        ST_GYRM, ST_LINM, ST_TRNM: begin
          num_r     <= MDU_N_W'(res_mag);
          num_neg_r <= res[MDU_R_W-1];
        end
        ST_LIND: lin_r  <= (us_r == '0) ? '0 : sat32(res);
        ST_TRND: turn_r <= (us_r == '0) ? '0 : sat32(res);
        default: ;
      endcase
    end
    case (state_r)
      ST_CWRP: z_r <= 34'(ang_w);
      ST_CRED: begin
        flip_r <= (z_r > 34'(HALF_PI_Q28)) || (z_r < -34'(HALF_PI_Q28));
        z_r    <= zr <<< 2;
        cx_r   <= GAIN_Q30;
        cy_r   <= '0;
        it_r   <= '0;
      end
      ST_CORD: begin
        if (z_r[33]) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
        end
        z_r  <= zs;
        it_r <= it_r + IT_W'(1);
      end
      ST_CFIN: begin
        cos_r <= 26'(xf >>> 8);
        sin_r <= 26'(yf >>> 8);
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/ddo_mdu.sv
// Shared iterative multiply / divide unit: shift-add multiply, restoring divide.
// Depends on ddo_pkg.
module ddo_mdu import ddo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ddo_cmd_t cmd,
  output ddo_rsp_t rsp
);

  logic                        busy_r;
  logic                        done_r;
  mdu_op_t                     op_r;
  logic                        neg_r;
  logic [MDU_CNT_W-1:0]        cnt_r;
  logic signed [MDU_R_W-1:0]   acc_r;
  logic signed [MDU_R_W-1:0]   mc_r;
  logic [MDU_N_W-1:0]          mb_r;
  logic [MDU_D_W-1:0]          rem_r;
  logic [MDU_D_W-1:0]          dvs_r;
  logic [MDU_D_W:0]            trial;
  logic                        ge;

  assign trial = {rem_r, mb_r[MDU_N_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == MDU_CNT_W'(1));
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == MDU_CNT_W'(1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= cmd.op;
      neg_r <= cmd.neg;
      if (cmd.op == MDU_DIV) begin
        cnt_r <= MDU_CNT_W'(MDU_DIV_CYC);
        acc_r <= '0;
        mb_r  <= cmd.num;
        rem_r <= '0;
        dvs_r <= cmd.den;
      end else begin
        cnt_r <= MDU_CNT_W'(MDU_MUL_CYC);
        acc_r <= cmd.accum ? acc_r : '0;
        mc_r  <= cmd.neg ? -MDU_R_W'($signed(cmd.a)) : MDU_R_W'($signed(cmd.a));
        mb_r  <= MDU_N_W'(cmd.b);
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - MDU_CNT_W'(1);
      if (op_r == MDU_DIV) begin
        rem_r <= ge ? MDU_D_W'(trial - {1'b0, dvs_r}) : trial[MDU_D_W-1:0];
        acc_r <= {acc_r[MDU_R_W-2:0], ge};
        mb_r  <= {mb_r[MDU_N_W-2:0], 1'b0};
      end else begin
        if (mb_r[0]) begin
          acc_r <= acc_r + mc_r;
        end
        mc_r <= mc_r <<< 1;
        mb_r <= mb_r >> 1;
      end
    end
  end

  always_comb begin
    rsp.done = done_r;
    rsp.res  = ((op_r == MDU_DIV) && neg_r) ? -acc_r : acc_r;
  end

endmodule

>>> rtl/ddo_chk.sv
// Port-level checker for the odometry block, bound to the top level.
// Depends on the macro header and ddo_pkg.
`include "diff_drive_odometry_gyro_fused_macros.svh"

module ddo_chk import ddo_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [HDG_W-1:0] out_heading
);

  `DDO_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `DDO_NEVER(a_one_item, in_ready && out_valid, "input taken while result pending")
  `DDO_ASSERT(a_no_instant, in_valid && in_ready |=> !out_valid, "result without work")
  `DDO_ASSERT(a_ready_after, out_valid && out_ready |=> in_ready, "not idle after transfer")
  `DDO_ASSERT(a_hdg_range, out_valid |-> (out_heading <= 31'(PI_Q28)) && (out_heading >= -31'(PI_Q28)), "heading out of range")

endmodule

bind diff_drive_odometry_gyro_fused ddo_chk u_ddo_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_heading(out_ch.heading)
);

>>> tb/tb_top.sv
// Testbench for diff_drive_odometry_gyro_fused: directed and random odometry items with
// a bit-exact pose/heading/speed predictor and a result scoreboard.
// Depends on ddo_pkg, ddo_in_if, ddo_out_if and the RTL top level.
module tb_top;
  import ddo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int FRAC = 16;
  localparam longint PI = 843314857;
  localparam longint TWO_PI = 1686629713;
  localparam longint HALF_PI = 421657428;
  localparam longint GAIN = 652032875;
  localparam longint TICK_MAX = 32767;
  localparam longint ENC_MAX = 64'sd1 << 46;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint ARCTAN [16] = '{210828714, 124459457, 65760959, 33381290, 16755422,
    8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192};

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [30:0] hdg;
    logic signed [31:0] lin;
    logic signed [31:0] turn;
    logic clip;
  } pose_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  ddo_in_if in_ch();
  ddo_out_if out_ch();

  diff_drive_odometry_gyro_fused u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  longint mpt = 9664, iwb = 409600, gw = 0;
  logic signed [31:0] last_right = 0, last_left = 0;
  longint x_pos = 0, y_pos = 0, theta = 0;

  pose_t pending_poses[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int clipped_seen = 0;
  longint cycles = 0;
  bit calm = 0;
  int hold_off = 0;

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic longint sat32(input longint v);
    return v < -64'sd2147483648 ? -64'sd2147483648 : (v > 64'sd2147483647 ? 64'sd2147483647 : v);
  endfunction

  function automatic pose_t odometry_step(input logic signed [31:0] rc, input logic signed [31:0] lc,
                                          input logic signed [19:0] yaw_in,
                                          input logic [19:0] us_in);
    logic signed [31:0] d32;
    longint dr, dl, distr, distl, distc, ddiff, enc, gyro, delta, w, yaw, us;
    longint z, xr, yr, t, c, s, lin, turn;
    longint unsigned mag;
    bit clip, flip;
    pose_t r;
    clip = 0;
    flip = 0;
    lin = 0;
    turn = 0;
    yaw = yaw_in;
    us = us_in;
    d32 = rc - last_right;
    dr = d32;
    d32 = last_left - lc;
    dl = d32;
    last_right = rc;
    last_left = lc;
    if (dr > TICK_MAX || dr < -TICK_MAX) begin
      dr = dr > 0 ? TICK_MAX : -TICK_MAX;
      clip = 1;
    end
    if (dl > TICK_MAX || dl < -TICK_MAX) begin
      dl = dl > 0 ? TICK_MAX : -TICK_MAX;
      clip = 1;
    end
    distr = dr * mpt;
    distl = dl * mpt;
    distc = (distr + distl) >>> 1;
    ddiff = distr - distl;
    mag = longint'(ddiff < 0 ? -ddiff : ddiff);
    mag = mag * longint'(iwb);
    mag = mag >> 12;
    if (mag > ENC_MAX) mag = ENC_MAX;
    enc = ddiff < 0 ? -longint'(mag) : longint'(mag);
    gyro = (yaw * us * 4096) / 1000000;
    w = gw > 65536 ? 65536 : gw;
    delta = (w * gyro + (65536 - w) * enc) >>> 16;
    if (delta > PI || delta < -PI) begin
      delta = delta > 0 ? PI : -PI;
      clip = 1;
    end
    z = theta + (delta >>> 1);
    if (z > PI) z -= TWO_PI;
    else if (z < -PI) z += TWO_PI;
    if (z > HALF_PI) begin
      z -= PI;
      flip = 1;
    end else if (z < -HALF_PI) begin
      z += PI;
      flip = 1;
    end
    z = z * 4;
    xr = GAIN;
    yr = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        t = xr - (yr >>> i); yr = yr + (xr >>> i); xr = t; z -= ARCTAN[i] * 4;
      end else begin
        t = xr + (yr >>> i); yr = yr - (xr >>> i); xr = t; z += ARCTAN[i] * 4;
      end
    end
    if (flip) begin
      xr = -xr;
      yr = -yr;
    end
    c = xr >>> 8;
    s = yr >>> 8;
    x_pos = sat32(x_pos + ((distc * c) >>> (46 - FRAC)));
    y_pos = sat32(y_pos + ((distc * s) >>> (46 - FRAC)));
    theta += delta;
    if (theta > PI) theta -= TWO_PI;
    else if (theta < -PI) theta += TWO_PI;
    if (us != 0) begin
      lin = sat32((distc * 1000000) / (us * 256));
      turn = sat32((delta * 1000000) / (us * 4096));
    end
    r.px = x_pos[31:0];
    r.py = y_pos[31:0];
    r.hdg = theta[30:0];
    r.lin = lin[31:0];
    r.turn = turn[31:0];
    r.clip = clip;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    errors++;
    $display("tb_top: result %0d field %s got %0d want %0d", checked, field, got, want);
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_ch.ready = 0;
    end else begin
      out_ch.ready = calm || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    pose_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_poses.size() == 0) begin
        errors++;
        $display("tb_top: result with nothing pending");
      end else begin
        want = pending_poses.pop_front();
        if (out_ch.pos_x !== want.px) report_mismatch("pos_x", out_ch.pos_x, want.px);
        if (out_ch.pos_y !== want.py) report_mismatch("pos_y", out_ch.pos_y, want.py);
        if (out_ch.heading !== want.hdg) report_mismatch("heading", out_ch.heading, want.hdg);
        if (out_ch.lin_speed !== want.lin)
          report_mismatch("lin_speed", out_ch.lin_speed, want.lin);
        if (out_ch.turn_rate !== want.turn)
          report_mismatch("turn_rate", out_ch.turn_rate, want.turn);
        if (out_ch.delta_clipped !== want.clip)
          report_mismatch("delta_clipped", out_ch.delta_clipped, want.clip);
        if (want.clip) clipped_seen++;
      end
      checked++;
    end
  end

  task automatic send_item(input logic signed [31:0] rc, input logic signed [31:0] lc,
                           input logic signed [19:0] yaw, input logic [19:0] us);
    if (!calm && $urandom_range(99) < 27) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.right_count = rc;
    in_ch.left_count = lc;
    in_ch.yaw_rate = yaw;
    in_ch.interval_us = us;
    do @(posedge clk); while (!in_ch.ready);
    pending_poses.push_back(odometry_step(rc, lc, yaw, us));
    sent++;
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic drain;
    while (pending_poses.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
    drain();
    cfg_we = 1;
    cfg_idx = idx;
    cfg_wdata = value[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      CFG_MPT: mpt = value & 64'hFFFFFF;
      CFG_IWB: iwb = value & 64'hFFFFFF;
      CFG_GW:  gw = value & 64'h1FFFF;
      default: ;
    endcase
  endtask

  task automatic send_step(input int dright, input int dleft, input logic signed [19:0] yaw,
                           input logic [19:0] us);
    send_item(last_right + dright, last_left - dleft, yaw, us);
  endtask

  task automatic test_defaults;
    send_step(0, 0, 0, 1000);
    send_step(1000, 1000, 0, 10000);
    send_step(500, -500, 20'sd65536, 20000);
    send_step(-2000, -1500, -20'sd65536, 1);
    send_step(300, 200, 20'sh7FFFF, 0);
    send_step(32767, 32767, 20'sh80000, 20'hFFFFF);
    send_step(-32767, -32767, 0, 1000000);
  endtask

  task automatic test_tick_clip;
    send_item(32'sh7FFFFFFF, 32'sh80000000, 0, 5000);
    send_item(32'sh80000000, 32'sh7FFFFFFF, 0, 5000);
    send_step(32768, -40000, 0, 5000);
  endtask

  task automatic test_register_extremes;
    write_reg(CFG_MPT, 24'hFFFFFF);
    write_reg(CFG_IWB, 24'hFFFFFF);
    send_step(32767, -32767, 0, 1000);
    send_step(32767, 32767, 0, 1);
    send_step(32767, 32767, 0, 1);
    write_reg(CFG_MPT, 1);
    write_reg(CFG_IWB, 1);
    send_step(100, -100, 0, 1000);
    write_reg(CFG_GW, 65536);
    send_step(0, 0, 20'sh7FFFF, 1000000);
    send_step(0, 0, 20'sh80000, 1000000);
    write_reg(CFG_GW, 131071);
    send_step(10, 20, 20'sd200000, 400000);
    write_reg(CFG_UNUSED, 24'hABCDEF);
    send_step(10, 20, -20'sd200000, 400000);
  endtask

  task automatic test_heading_wrap;
    write_reg(CFG_MPT, 9664);
    write_reg(CFG_IWB, 409600);
    write_reg(CFG_GW, 65536);
    repeat (5) send_step(50, 50, 20'sd196608, 500000);
    repeat (4) send_step(50, 50, -20'sd196608, 600000);
  endtask

  task automatic test_backpressure;
    drain();
    hold_off = 3000;
    repeat (6) send_step($urandom_range(0, 400), $urandom_range(0, 400), 0, 2000);
  endtask

  task automatic random_item;
    int dright, dleft;
    logic [19:0] us;
    dright = $urandom_range(99) < 8 ? int'($urandom) : $urandom_range(4000) - 2000;
    dleft = $urandom_range(99) < 8 ? int'($urandom) : $urandom_range(4000) - 2000;
    us = $urandom_range(99) < 10 ? 20'($urandom) : 20'($urandom_range(100000, 1000));
    send_step(dright, dleft, 20'($urandom), us);
  endtask

  task automatic test_random;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_MPT, 9664); write_reg(CFG_IWB, 409600); write_reg(CFG_GW, 0);
        end
        1: begin
          write_reg(CFG_MPT, $urandom_range(1, 24'hFFFFFF));
          write_reg(CFG_IWB, $urandom_range(1, 24'hFFFFFF));
          write_reg(CFG_GW, $urandom_range(0, 65536));
        end
        2: begin
          write_reg(CFG_MPT, $urandom_range(1000, 60000));
          write_reg(CFG_IWB, $urandom_range(100000, 2000000));
          write_reg(CFG_GW, $urandom_range(0, 131071));
        end
        default: begin
          write_reg(CFG_MPT, 24'hFFFFFF); write_reg(CFG_GW, 32768);
        end
      endcase
      calm = (phase == 2);
      repeat (100) random_item();
      calm = 0;
    end
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.right_count = 0;
    in_ch.left_count = 0;
    in_ch.yaw_rate = 0;
    in_ch.interval_us = 0;
    out_ch.ready = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_defaults();
    test_tick_clip();
    test_register_extremes();
    test_heading_wrap();
    test_backpressure();
    test_random();
    drain();
    repeat (500) @(posedge clk);
    $display("tb_top: %0d items sent, %0d results checked, %0d with clipped deltas",
             sent, checked, clipped_seen);
    $display("tb_top: covered tick and heading clipping, register extremes, wrap and stalls");
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/ddo_pkg.sv
rtl/ddo_in_if.sv
rtl/ddo_out_if.sv
rtl/ddo_mdu.sv
rtl/diff_drive_odometry_gyro_fused.sv
rtl/ddo_chk.sv
tb/tb_top.sv
